// ===== rtl/core/rmq_pkg.sv =====
// ----------------------------------------------------------------------------
// Rotation matrix to quaternion: shared types and constants
// Widths of the fixed-point datapath and the structs that travel between the
// pipeline sections.
// ----------------------------------------------------------------------------
package rmq_pkg;

  localparam int FRAC_BITS = 16;
  localparam int DATA_W    = 18;
  localparam int SUM_W     = DATA_W + 3;
  localparam int RAD_W     = DATA_W + 2;
  localparam int SQ_IN_W   = RAD_W + FRAC_BITS + 2;
  localparam int ROOT_W    = SQ_IN_W / 2;
  localparam int SQ_REM_W  = ROOT_W + 2;
  localparam int NUM_W     = DATA_W + 1;
  localparam int DVD_W     = NUM_W + FRAC_BITS;
  localparam int LANES     = 3;
  localparam int ENTRIES   = 9;

  localparam logic [1:0] SEL_TRACE = 2'd0;
  localparam logic [1:0] SEL_X     = 2'd1;
  localparam logic [1:0] SEL_Y     = 2'd2;
  localparam logic [1:0] SEL_Z     = 2'd3;

  typedef struct packed {
    logic [1:0]       sel;
    logic             invalid;
    logic [LANES-1:0] neg;
  } meta_t;

  typedef struct packed {
    meta_t                        meta;
    logic [RAD_W-1:0]             rad;
    logic [LANES-1:0][NUM_W-1:0]  mag;
  } prep_t;

  typedef struct packed {
    meta_t                        meta;
    logic [LANES-1:0][NUM_W-1:0]  mag;
    logic [SQ_IN_W-1:0]           x;
    logic [SQ_REM_W-1:0]          rem;
    logic [ROOT_W-1:0]            root;
  } sq_t;

  typedef struct packed {
    meta_t                        meta;
    logic [ROOT_W-1:0]            s;
    logic [LANES-1:0][DVD_W-1:0]  dvd;
    logic [LANES-1:0][ROOT_W-1:0] rem;
    logic [LANES-1:0][DVD_W-1:0]  quo;
  } dv_t;

endpackage

// ===== rtl/core/rotation_matrix_to_quaternion_core.sv =====
// Pipeline: 1 front stage, 19 root stages, 36 divider stages and 1 output
// stage between an accepted word and its result word. Throughput: one
// matrix per cycle while the output is not stalled; the one-digit-per-stage
// root and divider pipelines set the depth. A stall at the output holds the
// whole pipeline. Reset clears all valid bits; data registers are not reset.
// ----------------------------------------------------------------------------
// Rotation matrix to quaternion converter
// Shepperd's method in Q2.16 fixed point with saturated components.
// ----------------------------------------------------------------------------
module rotation_matrix_to_quaternion_core import rmq_pkg::*; (
  input  logic         clk_i,
  input  logic         rst_ni,
  input  logic         s_axis_tvalid,
  output logic         s_axis_tready,
  // row0_col0, row0_col1, row0_col2, row1_col0 .. row2_col2, zero fill
  input  logic [167:0] s_axis_tdata,
  output logic         m_axis_tvalid,
  input  logic         m_axis_tready,
  // quat_w, quat_x, quat_y, quat_z
  output logic [71:0]  m_axis_tdata,
  // case_taken, invalid
  output logic [2:0]   m_axis_tuser
);

  localparam logic [DVD_W-1:0] POS_LIM = DVD_W'((1 << (DATA_W-1)) - 1);
  localparam logic [DVD_W-1:0] NEG_LIM = DVD_W'(1 << (DATA_W-1));

  logic                           en;
  logic                           prep_v, sq_v, dv_v;
  prep_t                          prep;
  sq_t                            sq;
  dv_t                            dv;
  logic [ENTRIES-1:0][DATA_W-1:0] mat;
  logic [LANES-1:0][DATA_W-1:0]   lane;
  logic [3:0][DATA_W-1:0]         comp;
  logic [DATA_W-1:0]              lead;
  logic                           out_v_q;
  logic [71:0]                    tdata_q, tdata_d;
  logic [2:0]                     tuser_q;

  assign en            = !out_v_q || m_axis_tready;
  assign s_axis_tready = en;
  assign mat           = s_axis_tdata[ENTRIES*DATA_W-1:0];

  rmq_prep u_prep (
    .clk_i, .rst_ni, .en_i(en), .valid_i(s_axis_tvalid), .mat_i(mat),
    .valid_o(prep_v), .prep_o(prep)
  );

  rmq_sqrt u_sqrt (
    .clk_i, .rst_ni, .en_i(en), .valid_i(prep_v), .prep_i(prep),
    .valid_o(sq_v), .sq_o(sq)
  );

  rmq_div u_div (
    .clk_i, .rst_ni, .en_i(en), .valid_i(sq_v), .sq_i(sq),
    .valid_o(dv_v), .dv_o(dv)
  );

  always_comb begin
    lead = DATA_W'(dv.s >> 2);
    for (int l = 0; l < LANES; l++) begin
      if (dv.meta.neg[l]) begin
        lane[l] = (dv.quo[l] > NEG_LIM) ? NEG_LIM[DATA_W-1:0]
                                        : DATA_W'(-dv.quo[l]);
      end else begin
        lane[l] = (dv.quo[l] > POS_LIM) ? POS_LIM[DATA_W-1:0]
                                        : dv.quo[l][DATA_W-1:0];
      end
    end
    for (int k = 0; k < 4; k++) begin
      if (dv.meta.invalid) begin
        comp[k] = '0;
      end else if (2'(k) == dv.meta.sel) begin
        comp[k] = lead;
      end else if (2'(k) < dv.meta.sel) begin
        comp[k] = lane[k];
      end else begin
        comp[k] = lane[(k > 0) ? k-1 : 0];
      end
    end
    tdata_d = comp;
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_v_q <= 1'b0;
    end else if (en) begin
      out_v_q <= dv_v;
    end
  end

  always_ff @(posedge clk_i) begin
    if (en) begin
      tdata_q <= tdata_d;
      tuser_q <= {dv.meta.invalid, dv.meta.sel};
    end
  end

  assign m_axis_tvalid = out_v_q;
  assign m_axis_tdata  = tdata_q;
  assign m_axis_tuser  = tuser_q;

  a_invalid_zero: assert property (@(posedge clk_i) disable iff (!rst_ni)
    m_axis_tvalid && m_axis_tuser[2] |-> m_axis_tdata == '0)
    else $error("invalid result carries non-zero components");

  a_trace_valid: assert property (@(posedge clk_i) disable iff (!rst_ni)
    m_axis_tvalid && m_axis_tuser[1:0] == SEL_TRACE |-> !m_axis_tuser[2])
    else $error("positive trace branch flagged invalid");

  a_stall_only: assert property (@(posedge clk_i) disable iff (!rst_ni)
    !s_axis_tready |-> m_axis_tvalid && !m_axis_tready)
    else $error("input held off without an output stall");

  a_root_floor: assert property (@(posedge clk_i) disable iff (!rst_ni)
    dv_v && !dv.meta.invalid |-> dv.s >= ROOT_W'(1 << ((FRAC_BITS+2)/2)))
    else $error("root below the smallest valid radicand");

endmodule

// ===== rtl/core/rmq_prep.sv =====
// ----------------------------------------------------------------------------
// Rotation matrix to quaternion: front stage
// Forms the trace, picks the branch, the radicand and the three numerators.
// ----------------------------------------------------------------------------
module rmq_prep import rmq_pkg::*; (
  input  logic                             clk_i,
  input  logic                             rst_ni,
  input  logic                             en_i,
  input  logic                             valid_i,
  input  logic [ENTRIES-1:0][DATA_W-1:0]   mat_i,
  output logic                             valid_o,
  output prep_t                            prep_o
);

  logic signed [SUM_W-1:0] a [ENTRIES];
  logic signed [SUM_W-1:0] trace, rad;
  logic signed [SUM_W-1:0] n [LANES];
  logic signed [SUM_W-1:0] d_wx, d_wy, d_wz, s_xy, s_xz, s_yz, one;
  prep_t                   prep_d, prep_q;
  logic                    valid_q;

  always_comb begin
    for (int i = 0; i < ENTRIES; i++) begin
      a[i] = SUM_W'($signed(mat_i[i]));
    end
    one   = SUM_W'(1) <<< FRAC_BITS;
    trace = a[0] + a[4] + a[8];
    d_wx  = a[7] - a[5];
    d_wy  = a[2] - a[6];
    d_wz  = a[3] - a[1];
    s_xy  = a[1] + a[3];
    s_xz  = a[2] + a[6];
    s_yz  = a[5] + a[7];
    prep_d = '0;
    if (trace > 0) begin
      prep_d.meta.sel = SEL_TRACE;
      rad  = trace + one;
      n[0] = d_wx;
      n[1] = d_wy;
      n[2] = d_wz;
    end else if (a[0] > a[4] && a[0] > a[8]) begin
      prep_d.meta.sel = SEL_X;
      rad  = one + a[0] - a[4] - a[8];
      n[0] = d_wx;
      n[1] = s_xy;
      n[2] = s_xz;
    end else if (a[4] > a[8]) begin
      prep_d.meta.sel = SEL_Y;
      rad  = one + a[4] - a[0] - a[8];
      n[0] = d_wy;
      n[1] = s_xy;
      n[2] = s_yz;
    end else begin
      prep_d.meta.sel = SEL_Z;
      rad  = one + a[8] - a[0] - a[4];
      n[0] = d_wz;
      n[1] = s_xz;
      n[2] = s_yz;
    end
    prep_d.meta.invalid = (rad <= 0);
    prep_d.rad = (rad <= 0) ? '0 : rad[RAD_W-1:0];
    for (int l = 0; l < LANES; l++) begin
      prep_d.meta.neg[l] = n[l][SUM_W-1];
      prep_d.mag[l] = n[l][SUM_W-1] ? NUM_W'(-n[l]) : NUM_W'(n[l]);
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      valid_q <= 1'b0;
    end else if (en_i) begin
      valid_q <= valid_i;
    end
  end

  always_ff @(posedge clk_i) begin
    if (en_i) begin
      prep_q <= prep_d;
    end
  end

  assign valid_o = valid_q;
  assign prep_o  = prep_q;

endmodule

// ===== rtl/core/rmq_sqrt.sv =====
// ----------------------------------------------------------------------------
// Rotation matrix to quaternion: pipelined square root
// One restoring root digit per register stage, giving floor(sqrt(r * 2^(F+2))).
// ----------------------------------------------------------------------------
module rmq_sqrt import rmq_pkg::*; (
  input  logic  clk_i,
  input  logic  rst_ni,
  input  logic  en_i,
  input  logic  valid_i,
  input  prep_t prep_i,
  output logic  valid_o,
  output sq_t   sq_o
);

  logic valid_q [ROOT_W];
  sq_t  st_q    [ROOT_W];

  for (genvar k = 0; k < ROOT_W; k++) begin : g_stage
    sq_t                 cur, st_d;
    logic                v_in;
    logic [SQ_REM_W+1:0] acc, trial;

    if (k == 0) begin : g_first
      assign v_in = valid_i;
      assign cur  = {prep_i.meta, prep_i.mag,
                     {prep_i.rad, {(SQ_IN_W-RAD_W){1'b0}}},
                     {SQ_REM_W{1'b0}}, {ROOT_W{1'b0}}};
    end else begin : g_next
      assign v_in = valid_q[k-1];
      assign cur  = st_q[k-1];
    end

    always_comb begin
      acc   = {cur.rem, cur.x[SQ_IN_W-1 -: 2]};
      trial = {2'b00, cur.root, 2'b01};
      st_d  = cur;
      st_d.x = cur.x << 2;
      if (acc >= trial) begin
        st_d.rem  = SQ_REM_W'(acc - trial);
        st_d.root = {cur.root[ROOT_W-2:0], 1'b1};
      end else begin
        st_d.rem  = acc[SQ_REM_W-1:0];
        st_d.root = {cur.root[ROOT_W-2:0], 1'b0};
      end
    end

    always_ff @(posedge clk_i or negedge rst_ni) begin
      if (!rst_ni) begin
        valid_q[k] <= 1'b0;
      end else if (en_i) begin
        valid_q[k] <= v_in;
      end
    end

    always_ff @(posedge clk_i) begin
      if (en_i) begin
        st_q[k] <= st_d;
      end
    end
  end

  assign valid_o = valid_q[ROOT_W-1];
  assign sq_o    = st_q[ROOT_W-1];

endmodule

// ===== rtl/core/rmq_div.sv =====
// ----------------------------------------------------------------------------
// Rotation matrix to quaternion: pipelined dividers
// A set-up stage adds the rounding half divisor, then three lanes run a
// restoring division, one quotient bit per register stage.
// ----------------------------------------------------------------------------
module rmq_div import rmq_pkg::*; (
  input  logic clk_i,
  input  logic rst_ni,
  input  logic en_i,
  input  logic valid_i,
  input  sq_t  sq_i,
  output logic valid_o,
  output dv_t  dv_o
);

  localparam int NST = DVD_W + 1;

  logic valid_q [NST];
  dv_t  st_q    [NST];

  for (genvar k = 0; k < NST; k++) begin : g_stage
    dv_t  st_d;
    logic v_in;

    if (k == 0) begin : g_setup
      assign v_in = valid_i;

      always_comb begin
        st_d        = '0;
        st_d.meta   = sq_i.meta;
        st_d.s      = sq_i.root;
        for (int l = 0; l < LANES; l++) begin
          st_d.dvd[l] = {sq_i.mag[l], {FRAC_BITS{1'b0}}}
                        + DVD_W'(sq_i.root >> 1);
        end
      end
    end else begin : g_step
      dv_t             cur;
      logic [ROOT_W:0] acc;

      assign v_in = valid_q[k-1];
      assign cur  = st_q[k-1];

      always_comb begin
        acc  = '0;
        st_d = cur;
        for (int l = 0; l < LANES; l++) begin
          acc = {cur.rem[l], cur.dvd[l][DVD_W-1]};
          st_d.dvd[l] = cur.dvd[l] << 1;
          if (acc >= {1'b0, cur.s}) begin
            st_d.rem[l] = ROOT_W'(acc - {1'b0, cur.s});
            st_d.quo[l] = {cur.quo[l][DVD_W-2:0], 1'b1};
          end else begin
            st_d.rem[l] = acc[ROOT_W-1:0];
            st_d.quo[l] = {cur.quo[l][DVD_W-2:0], 1'b0};
          end
        end
      end
    end

    always_ff @(posedge clk_i or negedge rst_ni) begin
      if (!rst_ni) begin
        valid_q[k] <= 1'b0;
      end else if (en_i) begin
        valid_q[k] <= v_in;
      end
    end

    always_ff @(posedge clk_i) begin
      if (en_i) begin
        st_q[k] <= st_d;
      end
    end
  end

  assign valid_o = valid_q[NST-1];
  assign dv_o    = st_q[NST-1];

endmodule

// ===== bench/rotation_matrix_to_quaternion_core_test.sv =====
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// Rotation matrix to quaternion converter testbench
// Streams directed and random matrices into the core with random gaps on both
// sides, predicts each quaternion word and checks results in order.
// ----------------------------------------------------------------------------
module rotation_matrix_to_quaternion_core_test import rmq_pkg::*;;

  typedef logic signed [DATA_W-1:0] fx_t;

  typedef struct packed {
    logic       invalid;
    logic [1:0] sel;
    fx_t        qz;
    fx_t        qy;
    fx_t        qx;
    fx_t        qw;
  } quat_t;

  logic         clk_i;
  logic         rst_ni;
  logic         s_axis_tvalid;
  logic         s_axis_tready;
  logic [167:0] s_axis_tdata;
  logic         m_axis_tvalid;
  logic         m_axis_tready;
  logic [71:0]  m_axis_tdata;
  logic [2:0]   m_axis_tuser;

  logic [167:0] matrix_queue[$];
  quat_t        quat_queue[$];
  int           fail_count;
  int           in_count;
  int           out_count;
  int           total_items;
  int           send_gap;
  int           recv_gap;

  rotation_matrix_to_quaternion_core u_top (
    .clk_i         (clk_i),
    .rst_ni        (rst_ni),
    .s_axis_tvalid (s_axis_tvalid),
    .s_axis_tready (s_axis_tready),
    .s_axis_tdata  (s_axis_tdata),
    .m_axis_tvalid (m_axis_tvalid),
    .m_axis_tready (m_axis_tready),
    .m_axis_tdata  (m_axis_tdata),
    .m_axis_tuser  (m_axis_tuser)
  );

  function automatic longint unsigned int_sqrt(longint unsigned x);
    longint unsigned res;
    longint unsigned b;
    res = 0;
    b = 64'd1 << 62;
    while (b > x) b >>= 2;
    while (b != 0) begin
      if (x >= res + b) begin
        x -= res + b;
        res = (res >> 1) + b;
      end else begin
        res >>= 1;
      end
      b >>= 2;
    end
    return res;
  endfunction

  function automatic fx_t clamp(longint v);
    if (v > 131071) return fx_t'(131071);
    if (v < -131072) return fx_t'(-131072);
    return fx_t'(v);
  endfunction

  function automatic fx_t scaled_ratio(longint n, longint unsigned s);
    longint unsigned mag;
    longint q;
    mag = (n < 0) ? longint'(-n) : longint'(n);
    q = longint'(((mag << FRAC_BITS) + (s >> 1)) / s);
    return clamp((n < 0) ? -q : q);
  endfunction

  function automatic quat_t matrix_to_quat(logic [167:0] d);
    longint a[9];
    longint tr;
    longint rad;
    longint unsigned s;
    fx_t lead;
    quat_t q;
    for (int i = 0; i < 9; i++) a[i] = longint'(fx_t'(d[i*DATA_W +: DATA_W]));
    q = '0;
    tr = a[0] + a[4] + a[8];
    if (tr > 0) begin
      q.sel = SEL_TRACE;
      rad = tr + (64'd1 << FRAC_BITS);
    end else if (a[0] > a[4] && a[0] > a[8]) begin
      q.sel = SEL_X;
      rad = (64'd1 << FRAC_BITS) + a[0] - a[4] - a[8];
    end else if (a[4] > a[8]) begin
      q.sel = SEL_Y;
      rad = (64'd1 << FRAC_BITS) + a[4] - a[0] - a[8];
    end else begin
      q.sel = SEL_Z;
      rad = (64'd1 << FRAC_BITS) + a[8] - a[0] - a[4];
    end
    if (rad <= 0) begin
      q.invalid = 1'b1;
      return q;
    end
    s = int_sqrt(longint'(rad) << (FRAC_BITS + 2));
    lead = clamp(longint'(s >> 2));
    if (s == 0) s = 1;
    case (q.sel)
      SEL_TRACE: begin
        q.qw = lead;
        q.qx = scaled_ratio(a[7] - a[5], s);
        q.qy = scaled_ratio(a[2] - a[6], s);
        q.qz = scaled_ratio(a[3] - a[1], s);
      end
      SEL_X: begin
        q.qw = scaled_ratio(a[7] - a[5], s);
        q.qx = lead;
        q.qy = scaled_ratio(a[1] + a[3], s);
        q.qz = scaled_ratio(a[2] + a[6], s);
      end
      SEL_Y: begin
        q.qw = scaled_ratio(a[2] - a[6], s);
        q.qx = scaled_ratio(a[1] + a[3], s);
        q.qy = lead;
        q.qz = scaled_ratio(a[5] + a[7], s);
      end
      default: begin
        q.qw = scaled_ratio(a[3] - a[1], s);
        q.qx = scaled_ratio(a[2] + a[6], s);
        q.qy = scaled_ratio(a[5] + a[7], s);
        q.qz = lead;
      end
    endcase
    return q;
  endfunction

  function automatic logic [167:0] pack_matrix(longint m[9]);
    logic [167:0] d;
    d = '0;
    for (int i = 0; i < 9; i++) d[i*DATA_W +: DATA_W] = fx_t'(m[i]);
    return d;
  endfunction

  function automatic longint near_value(longint base, int spread);
    longint v;
    v = base + longint'($urandom_range(2 * spread)) - spread;
    if (v > 131071) v = 131071;
    if (v < -131072) v = -131072;
    return v;
  endfunction

  function automatic logic [167:0] random_matrix();
    longint m[9];
    int kind;
    int ax;
    int sg;
    kind = $urandom_range(9);
    for (int i = 0; i < 9; i++) m[i] = longint'(fx_t'($urandom));
    if (kind < 6) begin
      // Near a signed permutation, so that each branch is reached with sane sums.
      ax = $urandom_range(3);
      for (int i = 0; i < 9; i++) m[i] = near_value(0, 40000);
      if (ax == 0) begin
        for (int i = 0; i < 3; i++) m[4*i] = near_value(65536, 30000);
      end else begin
        for (int i = 0; i < 3; i++) begin
          sg = (i == ax - 1) ? 65536 : -65536;
          m[4*i] = near_value(sg, 20000);
        end
      end
    end else if (kind < 8) begin
      for (int i = 0; i < 9; i++) m[i] = near_value(0, $urandom_range(1, 200));
    end
    return pack_matrix(m);
  endfunction

  initial begin
    clk_i = 1'b0;
    forever #1 clk_i = ~clk_i;
  end

  initial begin
    longint m[9];
    logic [167:0] d;
    rst_ni = 1'b0;
    fail_count = 0;
    for (int i = 0; i < 9; i++) m[i] = 0;
    m[0] = 65536; m[4] = 65536; m[8] = 65536;
    matrix_queue.push_back(pack_matrix(m));
    m[0] = 65536; m[4] = -65536; m[8] = -65536;
    matrix_queue.push_back(pack_matrix(m));
    m[0] = -65536; m[4] = 65536; m[8] = -65536;
    matrix_queue.push_back(pack_matrix(m));
    m[0] = -65536; m[4] = -65536; m[8] = 65536;
    matrix_queue.push_back(pack_matrix(m));
    for (int i = 0; i < 9; i++) m[i] = 0;
    matrix_queue.push_back(pack_matrix(m));
    for (int i = 0; i < 9; i++) m[i] = 131071;
    matrix_queue.push_back(pack_matrix(m));
    for (int i = 0; i < 9; i++) m[i] = -131072;
    matrix_queue.push_back(pack_matrix(m));
    for (int i = 0; i < 9; i++) m[i] = (i % 2) ? -131072 : 131071;
    matrix_queue.push_back(pack_matrix(m));
    for (int i = 0; i < 9; i++) m[i] = (i % 2) ? 131071 : -131072;
    matrix_queue.push_back(pack_matrix(m));
    for (int i = 0; i < 9; i++) m[i] = 0;
    m[0] = -131072; m[4] = -131072; m[8] = -131072;
    matrix_queue.push_back(pack_matrix(m));
    m[0] = -10; m[4] = -10; m[8] = -20;
    matrix_queue.push_back(pack_matrix(m));
    m[0] = -20; m[4] = -10; m[8] = -10;
    matrix_queue.push_back(pack_matrix(m));
    m[0] = 1; m[4] = 0; m[8] = -1;
    matrix_queue.push_back(pack_matrix(m));
    m[0] = -131072; m[4] = -131072; m[8] = 131071;
    m[1] = 131071; m[3] = 131071; m[2] = -131072; m[6] = -131072;
    matrix_queue.push_back(pack_matrix(m));
    for (int i = 0; i < 9; i++) m[i] = 0;
    m[0] = 1; m[7] = 131071; m[5] = -131072;
    matrix_queue.push_back(pack_matrix(m));
    m[0] = -65536; m[4] = -65536; m[8] = -65535;
    matrix_queue.push_back(pack_matrix(m));
    m[8] = -65536;
    matrix_queue.push_back(pack_matrix(m));
    for (int i = 0; i < 650; i++) matrix_queue.push_back(random_matrix());
    total_items = matrix_queue.size();
    repeat (10) @(posedge clk_i);
    rst_ni <= 1'b1;
  end

  always @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      s_axis_tvalid <= 1'b0;
      s_axis_tdata  <= '0;
      send_gap      <= 0;
      in_count      <= 0;
    end else begin
      if (s_axis_tvalid && s_axis_tready) begin
        quat_queue.push_back(matrix_to_quat(s_axis_tdata));
        in_count <= in_count + 1;
      end
      if (!s_axis_tvalid || s_axis_tready) begin
        if (send_gap > 0) begin
          send_gap      <= send_gap - 1;
          s_axis_tvalid <= 1'b0;
        end else if (matrix_queue.size() > 0) begin
          s_axis_tvalid <= 1'b1;
          s_axis_tdata  <= matrix_queue.pop_front();
          if (matrix_queue.size() > 60 && $urandom_range(5) == 0) begin
            send_gap <= $urandom_range(1, 6);
          end
        end else begin
          s_axis_tvalid <= 1'b0;
        end
      end
    end
  end

  always @(posedge clk_i or negedge rst_ni) begin
    quat_t got;
    quat_t want;
    if (!rst_ni) begin
      m_axis_tready <= 1'b0;
      recv_gap      <= 0;
      out_count     <= 0;
    end else begin
      if (m_axis_tvalid && m_axis_tready) begin
        got = {m_axis_tuser[2], m_axis_tuser[1:0], m_axis_tdata};
        out_count <= out_count + 1;
        if (quat_queue.size() == 0) begin
          $display("%0t: unexpected word %h", $time, got);
          fail_count++;
        end else begin
          want = quat_queue.pop_front();
          if (got !== want) begin
            $display("%0t: mismatch expected w %0d x %0d y %0d z %0d case %0d inv %0b",
                     $time, want.qw, want.qx, want.qy, want.qz, want.sel, want.invalid);
            $display("%0t:          actual   w %0d x %0d y %0d z %0d case %0d inv %0b",
                     $time, got.qw, got.qx, got.qy, got.qz, got.sel, got.invalid);
            fail_count++;
          end
        end
      end
      if (recv_gap > 0) begin
        recv_gap      <= recv_gap - 1;
        m_axis_tready <= 1'b0;
      end else begin
        m_axis_tready <= 1'b1;
        if (out_count < total_items - 60 && $urandom_range(5) == 0) begin
          recv_gap <= $urandom_range(1, 6);
        end
      end
    end
  end

  initial begin
    wait (rst_ni);
    wait (in_count == total_items && quat_queue.size() == 0);
    repeat (100) @(posedge clk_i);
    if (fail_count == 0) begin
      $display("Test completed successfully");
    end else begin
      $display("Test completed with failures");
    end
    $finish;
  end

  initial begin
    #200000;
    $display("Test completed with failures");
    $finish;
  end

endmodule
